// ===== hdl/byte_taint_propagation_defines.svh =====
// Assertion macros used by the port-level checker of the byte taint tracker.
`ifndef BYTE_TAINT_PROPAGATION_DEFINES_SVH
`define BYTE_TAINT_PROPAGATION_DEFINES_SVH

// Check a consequence in the same cycle as its condition.
`define BTP_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check a consequence in the cycle after its condition.
`define BTP_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hdl/btp_pkg.sv =====
// Shared constants, command types and helper functions of the byte taint tracker.
package btp_pkg;

    localparam int ADDRESS_BITS   = 16;
    localparam int REGISTER_COUNT = 16;
    localparam int REGISTER_BYTES = 16;
    localparam int MAX_SPAN       = 256;

    // Shadow memory is kept as rows of sixteen taint bits.
    localparam int ROW_BYTES = 16;
    localparam int LANE_BITS = 4;
    localparam int ROW_BITS  = ADDRESS_BITS - LANE_BITS;
    localparam int ROWS      = 2 ** ROW_BITS;
    localparam int SPAN_BITS = 9;
    localparam int RIDX_BITS = 4;
    localparam int PART_BITS = 3;
    localparam int OP_BITS   = 4;
    localparam int MASK_BITS = 16;

    localparam logic [OP_BITS-1:0] OP_TAINT_MEM   = 4'd0;
    localparam logic [OP_BITS-1:0] OP_UNTAINT_MEM = 4'd1;
    localparam logic [OP_BITS-1:0] OP_TAINT_REG   = 4'd2;
    localparam logic [OP_BITS-1:0] OP_UNTAINT_REG = 4'd3;
    localparam logic [OP_BITS-1:0] OP_REG_TO_MEM  = 4'd4;
    localparam logic [OP_BITS-1:0] OP_MEM_TO_REG  = 4'd5;
    localparam logic [OP_BITS-1:0] OP_REG_TO_REG  = 4'd6;
    localparam logic [OP_BITS-1:0] OP_MEM_TO_MEM  = 4'd7;
    localparam logic [OP_BITS-1:0] OP_QUERY_MEM   = 4'd8;
    localparam logic [OP_BITS-1:0] OP_QUERY_REG   = 4'd9;
    localparam logic [OP_BITS-1:0] OP_CLEAR       = 4'd10;

    localparam logic [PART_BITS-1:0] PART_LOW   = 3'd0;
    localparam logic [PART_BITS-1:0] PART_HIGH  = 3'd1;
    localparam logic [PART_BITS-1:0] PART_WORD  = 3'd2;
    localparam logic [PART_BITS-1:0] PART_DWORD = 3'd3;
    localparam logic [PART_BITS-1:0] PART_QWORD = 3'd4;
    localparam logic [PART_BITS-1:0] PART_OWORD = 3'd5;

    // One classified operation as handed from the front to the engine.
    typedef struct packed {
        logic [OP_BITS-1:0]        op;
        logic [ADDRESS_BITS-1:0]   addr;
        logic [ADDRESS_BITS-1:0]   saddr;
        logic [SPAN_BITS-1:0]      count;
        logic [RIDX_BITS-1:0]      ri;
        logic [RIDX_BITS-1:0]      si;
        logic                      reg_ok;
        logic                      src_ok;
        logic [REGISTER_BYTES-1:0] pmask;
        logic                      rsel;
        logic                      ssel;
        logic                      byte_copy;
        logic                      copy_ok;
    } cmd_t;

    // Engine status seen by the front.
    typedef struct packed {
        logic init_busy;
    } status_t;

    // Bytes selected by a register part code.
    function automatic logic [REGISTER_BYTES-1:0] part_mask(logic [PART_BITS-1:0] p);
        logic [REGISTER_BYTES-1:0] m;
        m = '0;
        unique case (p)
            PART_LOW:   m[0] = 1'b1;
            PART_HIGH:  m[1] = 1'b1;
            PART_WORD:  m = REGISTER_BYTES'(32'h0000_0003);
            PART_DWORD: m = REGISTER_BYTES'(32'h0000_000F);
            PART_QWORD: m = REGISTER_BYTES'(32'h0000_00FF);
            PART_OWORD: m = REGISTER_BYTES'(32'h0000_FFFF);
            default:    m = '0;
        endcase
        return m;
    endfunction

    // Number of low bytes of a wide part, clipped to the register size.
    function automatic logic [SPAN_BITS-1:0] part_bytes(logic [PART_BITS-1:0] p);
        logic [SPAN_BITS-1:0] n;
        n = '0;
        unique case (p)
            PART_LOW, PART_HIGH: n = SPAN_BITS'(1);
            PART_WORD:  n = SPAN_BITS'(2);
            PART_DWORD: n = SPAN_BITS'(4);
            PART_QWORD: n = SPAN_BITS'(8);
            PART_OWORD: n = SPAN_BITS'(16);
            default:    n = '0;
        endcase
        if (n > SPAN_BITS'(REGISTER_BYTES))
        begin
            n = SPAN_BITS'(REGISTER_BYTES);
        end
        return n;
    endfunction

endpackage

// ===== hdl/byte_taint_propagation.sv =====
// Top level of the byte taint tracker: front, command queue and engine.
//
//  channel   dir  payload (tdata, low bit first)
//  s_axis    in   op, address, source address, span, reg, part, src reg, src part
//  m_axis    out  taint mask, any tainted
//
// A range walks the 16-byte shadow rows through the shadow RAM, reading and then
// writing each row, and a memory to memory copy moves one byte at a time through
// a source read, a destination read and a destination write.
// After reset the shadow RAM is swept row by row; no transaction is taken
// meanwhile. A clear operation repeats that sweep.
// The queue keeps taking up to two transactions while the result waits.
module byte_taint_propagation (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    // req_type[3:0], address[19:4], source_address[35:20], span[44:36],
    // register_index[48:45], register_part[51:49], source_register[55:52],
    // source_part[58:56], zero fill
    input  logic [63:0] s_tdata,
    output logic        m_tvalid,
    input  logic        m_tready,
    // taint_mask[15:0], any_tainted[16], zero fill
    output logic [23:0] m_tdata
);

    btp_pkg::cmd_t    push_cmd;
    btp_pkg::cmd_t    head_cmd;
    btp_pkg::status_t status;
    logic             push;
    logic             pop;
    logic             q_full;
    logic             q_valid;

    btp_front u_front (
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .q_full   (q_full),
        .status   (status),
        .push     (push),
        .cmd      (push_cmd)
    );

    btp_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_cmd (push_cmd),
        .pop      (pop),
        .full     (q_full),
        .valid    (q_valid),
        .head     (head_cmd)
    );

    btp_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .q_valid  (q_valid),
        .q_cmd    (head_cmd),
        .q_pop    (pop),
        .status   (status),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

endmodule

// ===== hdl/btp_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module btp_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 4096
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port and registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== hdl/btp_front.sv =====
// Input side: accepts transactions and classifies them into engine commands.
module btp_front (
    input  logic             s_tvalid,
    output logic             s_tready,
    input  logic [63:0]      s_tdata,
    input  logic             q_full,
    input  btp_pkg::status_t status,
    output logic             push,
    output btp_pkg::cmd_t    cmd
);

    logic [btp_pkg::OP_BITS-1:0]      op;
    logic [btp_pkg::ADDRESS_BITS-1:0] addr;
    logic [btp_pkg::ADDRESS_BITS-1:0] saddr;
    logic [btp_pkg::SPAN_BITS-1:0]    span;
    logic [btp_pkg::RIDX_BITS-1:0]    ri;
    logic [btp_pkg::PART_BITS-1:0]    rp;
    logic [btp_pkg::RIDX_BITS-1:0]    si;
    logic [btp_pkg::PART_BITS-1:0]    sp;
    logic [btp_pkg::SPAN_BITS-1:0]    span_clip;
    logic [btp_pkg::SPAN_BITS-1:0]    span_query;

    // Unpack the payload
    assign op    = s_tdata[3:0];
    assign addr  = s_tdata[19:4];
    assign saddr = s_tdata[35:20];
    assign span  = s_tdata[44:36];
    assign ri    = s_tdata[48:45];
    assign rp    = s_tdata[51:49];
    assign si    = s_tdata[55:52];
    assign sp    = s_tdata[58:56];

    // Hold off while the queue is full or the store is being swept after reset
    assign s_tready = !q_full && !status.init_busy;
    assign push     = s_tvalid && s_tready;

    // Saturate span counts
    assign span_clip  = (span > btp_pkg::SPAN_BITS'(btp_pkg::MAX_SPAN)) ?
                        btp_pkg::SPAN_BITS'(btp_pkg::MAX_SPAN) : span;
    assign span_query = (span > btp_pkg::SPAN_BITS'(btp_pkg::ROW_BYTES)) ?
                        btp_pkg::SPAN_BITS'(btp_pkg::ROW_BYTES) : span;

    // Classify the operation
    always_comb
    begin
        cmd           = '0;
        cmd.op        = op;
        cmd.addr      = addr;
        cmd.saddr     = saddr;
        cmd.ri        = ri;
        cmd.si        = si;
        cmd.reg_ok    = ({1'b0, ri} < (btp_pkg::RIDX_BITS + 1)'(btp_pkg::REGISTER_COUNT));
        cmd.src_ok    = ({1'b0, si} < (btp_pkg::RIDX_BITS + 1)'(btp_pkg::REGISTER_COUNT));
        cmd.pmask     = btp_pkg::part_mask(rp);
        cmd.rsel      = (rp == btp_pkg::PART_HIGH);
        cmd.ssel      = (sp == btp_pkg::PART_HIGH);
        cmd.byte_copy = (rp <= btp_pkg::PART_HIGH) && (sp <= btp_pkg::PART_HIGH);
        cmd.copy_ok   = (btp_pkg::part_mask(rp) != '0) && (btp_pkg::part_mask(sp) != '0);
        unique case (op) inside
            btp_pkg::OP_TAINT_MEM, btp_pkg::OP_UNTAINT_MEM, btp_pkg::OP_MEM_TO_MEM:
                cmd.count = span_clip;
            btp_pkg::OP_QUERY_MEM:
                cmd.count = span_query;
            btp_pkg::OP_REG_TO_MEM, btp_pkg::OP_MEM_TO_REG:
                cmd.count = btp_pkg::part_bytes(rp);
            default:
                cmd.count = '0;
        endcase
    end

endmodule

// ===== hdl/btp_queue.sv =====
// Two-entry command queue between the front and the engine.
module btp_queue (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  btp_pkg::cmd_t push_cmd,
    input  logic          pop,
    output logic          full,
    output logic          valid,
    output btp_pkg::cmd_t head
);

    btp_pkg::cmd_t entry_reg [2];
    logic          wr_ptr_reg, wr_ptr_next;
    logic          rd_ptr_reg, rd_ptr_next;
    logic [1:0]    fill_reg, fill_next;

    assign full  = (fill_reg == 2'd2);
    assign valid = (fill_reg != 2'd0);
    assign head  = entry_reg[rd_ptr_reg];

    // Advance pointers and fill level
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg ^ push;
        rd_ptr_next = rd_ptr_reg ^ pop;
        fill_next   = fill_reg + 2'(push) - 2'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            fill_reg   <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    // Store pushed commands
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

// ===== hdl/btp_back.sv =====
// Engine: carries out commands on the shadow stores and posts results.
module btp_back (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             q_valid,
    input  btp_pkg::cmd_t    q_cmd,
    output logic             q_pop,
    output btp_pkg::status_t status,
    output logic             m_tvalid,
    input  logic             m_tready,
    output logic [23:0]      m_tdata
);

    localparam logic [3:0] ST_IDLE      = 4'd0;
    localparam logic [3:0] ST_CLEAR     = 4'd1;
    localparam logic [3:0] ST_REG_READ  = 4'd2;
    localparam logic [3:0] ST_REG_WRITE = 4'd3;
    localparam logic [3:0] ST_ROW_READ  = 4'd4;
    localparam logic [3:0] ST_ROW_WRITE = 4'd5;
    localparam logic [3:0] ST_COPY_SRC  = 4'd6;
    localparam logic [3:0] ST_COPY_MID  = 4'd7;
    localparam logic [3:0] ST_COPY_DST  = 4'd8;
    localparam logic [3:0] ST_DONE      = 4'd9;

    localparam int RB = btp_pkg::REGISTER_BYTES;
    localparam int RW = btp_pkg::ROW_BYTES;
    localparam int AB = btp_pkg::ADDRESS_BITS;
    localparam int LB = btp_pkg::LANE_BITS;
    localparam int WB = btp_pkg::ROW_BITS;
    localparam int SB = btp_pkg::SPAN_BITS;
    localparam logic [WB-1:0] ROW_LAST = WB'(btp_pkg::ROWS - 1);

    logic [3:0]                     state_reg, state_next;
    btp_pkg::cmd_t                  cmd_reg, cmd_next;
    logic [SB-1:0]                  step_reg, step_next;
    logic [btp_pkg::MASK_BITS-1:0]  acc_reg, acc_next;
    logic [RB-1:0]                  regbuf_reg, regbuf_next;
    logic                           bit_reg, bit_next;
    logic [WB-1:0]                  clr_reg, clr_next;
    logic                           init_reg, init_next;
    logic                           out_valid_reg, out_valid_next;
    logic [btp_pkg::MASK_BITS-1:0]  out_mask_reg, out_mask_next;
    logic [RB-1:0]                  rf_reg [btp_pkg::REGISTER_COUNT];

    logic          ram_we;
    logic [WB-1:0] ram_waddr;
    logic [RW-1:0] ram_wdata;
    logic [WB-1:0] ram_raddr;
    logic [RW-1:0] ram_rdata;

    logic          rf_we;
    logic          rf_clear;
    logic [RB-1:0] rf_mask;
    logic [RB-1:0] rf_val;
    logic [RB-1:0] rd_data;

    logic [LB-1:0]                  lo;
    logic [WB-1:0]                  row_addr;
    logic                           more_rows;
    logic [AB-1:0]                  src_byte;
    logic [AB-1:0]                  dst_byte;
    logic [RW-1:0]                  lane_mask;
    logic [RW-1:0]                  lane_val;
    logic [btp_pkg::MASK_BITS-1:0]  gather;
    logic [RW-1:0]                  copy_word;

    btp_ram #(
        .WIDTH (RW),
        .DEPTH (btp_pkg::ROWS)
    ) u_shadow (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign status.init_busy = init_reg;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {7'd0, (out_mask_reg != '0), out_mask_reg};

    // Read one register: the source for a register copy, else the named one
    always_comb
    begin
        logic [btp_pkg::RIDX_BITS-1:0] idx;
        logic                          ok;
        idx = (cmd_reg.op == btp_pkg::OP_REG_TO_REG) ? cmd_reg.si : cmd_reg.ri;
        ok  = (cmd_reg.op == btp_pkg::OP_REG_TO_REG) ? cmd_reg.src_ok : cmd_reg.reg_ok;
        rd_data = '0;
        for (int e = 0; e < btp_pkg::REGISTER_COUNT; e++)
        begin
            if (ok && (idx == btp_pkg::RIDX_BITS'(e)))
            begin
                rd_data = rf_reg[e];
            end
        end
    end

    // Row walk addressing
    assign lo        = cmd_reg.addr[LB-1:0];
    assign row_addr  = cmd_reg.addr[AB-1:LB] + WB'(step_reg);
    assign more_rows = ({step_reg, {LB{1'b0}}} < ((SB + LB)'(lo) + (SB + LB)'(cmd_reg.count)));
    assign src_byte  = cmd_reg.saddr + AB'(step_reg);
    assign dst_byte  = cmd_reg.addr + AB'(step_reg);

    // Lanes of the current row that fall inside the range, and their new taint
    always_comb
    begin
        logic [9:0]    off;
        logic [9:0]    rel;
        logic [RB-1:0] regsh;
        regsh = regbuf_reg >> cmd_reg.rsel;
        for (int j = 0; j < RW; j++)
        begin
            off = {step_reg[5:0], LB'(j)};
            rel = off - 10'(lo);
            lane_mask[j] = (off >= 10'(lo)) && (rel < 10'(cmd_reg.count));
            unique case (cmd_reg.op) inside
                btp_pkg::OP_TAINT_MEM:  lane_val[j] = 1'b1;
                btp_pkg::OP_REG_TO_MEM: lane_val[j] = (rel < 10'(RB)) ? regsh[rel[LB-1:0]] : 1'b0;
                default:                lane_val[j] = 1'b0;
            endcase
        end
    end

    // Collect queried bytes of the current row into result positions
    always_comb
    begin
        logic [LB:0] o;
        gather = '0;
        for (int k = 0; k < btp_pkg::MASK_BITS; k++)
        begin
            o = (LB + 1)'(k) + (LB + 1)'(lo);
            if ((o[LB] == step_reg[0]) && (step_reg[SB-1:1] == '0) &&
                (SB'(k) < cmd_reg.count))
            begin
                gather[k] = ram_rdata[o[LB-1:0]];
            end
        end
    end

    // Destination row with the copied bit dropped in
    always_comb
    begin
        copy_word = ram_rdata;
        copy_word[dst_byte[LB-1:0]] = bit_reg;
    end

    // Sequencer
    always_comb
    begin
        state_next     = state_reg;
        cmd_next       = cmd_reg;
        step_next      = step_reg;
        acc_next       = acc_reg;
        regbuf_next    = regbuf_reg;
        bit_next       = bit_reg;
        clr_next       = clr_reg;
        init_next      = init_reg;
        out_valid_next = out_valid_reg && !m_tready;
        out_mask_next  = out_mask_reg;
        q_pop          = 1'b0;
        ram_raddr      = row_addr;
        ram_we         = 1'b0;
        ram_waddr      = row_addr;
        ram_wdata      = '0;
        rf_we          = 1'b0;
        rf_clear       = 1'b0;
        rf_mask        = cmd_reg.pmask;
        rf_val         = '0;
        unique case (state_reg)
            ST_CLEAR:
            begin
                ram_we    = 1'b1;
                ram_waddr = clr_reg;
                ram_wdata = '0;
                clr_next  = clr_reg + WB'(1);
                if (clr_reg == ROW_LAST)
                begin
                    state_next = init_reg ? ST_IDLE : ST_DONE;
                    init_next  = 1'b0;
                end
            end
            ST_IDLE:
            begin
                if (q_valid && (!out_valid_reg || m_tready))
                begin
                    q_pop     = 1'b1;
                    cmd_next  = q_cmd;
                    step_next = '0;
                    acc_next  = '0;
                    unique case (q_cmd.op) inside
                        btp_pkg::OP_TAINT_MEM, btp_pkg::OP_UNTAINT_MEM,
                        btp_pkg::OP_QUERY_MEM, btp_pkg::OP_MEM_TO_REG:
                            state_next = ST_ROW_READ;
                        btp_pkg::OP_REG_TO_MEM, btp_pkg::OP_REG_TO_REG,
                        btp_pkg::OP_QUERY_REG:
                            state_next = ST_REG_READ;
                        btp_pkg::OP_TAINT_REG, btp_pkg::OP_UNTAINT_REG:
                            state_next = ST_REG_WRITE;
                        btp_pkg::OP_MEM_TO_MEM:
                            state_next = ST_COPY_SRC;
                        btp_pkg::OP_CLEAR:
                        begin
                            rf_clear   = 1'b1;
                            clr_next   = '0;
                            state_next = ST_CLEAR;
                        end
                        default:
                            state_next = ST_DONE;
                    endcase
                end
            end
            ST_REG_READ:
            begin
                regbuf_next = rd_data;
                unique case (cmd_reg.op) inside
                    btp_pkg::OP_QUERY_REG:
                    begin
                        acc_next   = btp_pkg::MASK_BITS'(rd_data & cmd_reg.pmask);
                        state_next = ST_DONE;
                    end
                    btp_pkg::OP_REG_TO_REG:
                        state_next = ST_REG_WRITE;
                    default:
                        state_next = ST_ROW_READ;
                endcase
            end
            ST_REG_WRITE:
            begin
                unique case (cmd_reg.op) inside
                    btp_pkg::OP_TAINT_REG:
                    begin
                        rf_we  = cmd_reg.reg_ok;
                        rf_val = '1;
                    end
                    btp_pkg::OP_UNTAINT_REG:
                    begin
                        rf_we  = cmd_reg.reg_ok;
                        rf_val = '0;
                    end
                    btp_pkg::OP_MEM_TO_REG:
                    begin
                        rf_we  = cmd_reg.reg_ok;
                        rf_val = RB'(acc_reg) << cmd_reg.rsel;
                    end
                    btp_pkg::OP_REG_TO_REG:
                    begin
                        if (cmd_reg.byte_copy)
                        begin
                            rf_we  = cmd_reg.reg_ok;
                            rf_val = {RB{regbuf_reg[cmd_reg.ssel]}};
                        end
                        else
                        begin
                            rf_we  = cmd_reg.reg_ok && cmd_reg.copy_ok;
                            rf_val = regbuf_reg;
                        end
                    end
                    default:
                        rf_we = 1'b0;
                endcase
                state_next = ST_DONE;
            end
            ST_ROW_READ:
            begin
                if (more_rows)
                begin
                    state_next = ST_ROW_WRITE;
                end
                else if (cmd_reg.op == btp_pkg::OP_MEM_TO_REG)
                begin
                    state_next = ST_REG_WRITE;
                end
                else
                begin
                    state_next = ST_DONE;
                end
            end
            ST_ROW_WRITE:
            begin
                unique case (cmd_reg.op) inside
                    btp_pkg::OP_TAINT_MEM, btp_pkg::OP_UNTAINT_MEM, btp_pkg::OP_REG_TO_MEM:
                    begin
                        ram_we    = 1'b1;
                        ram_wdata = (ram_rdata & ~lane_mask) | (lane_val & lane_mask);
                    end
                    default:
                        acc_next = acc_reg | gather;
                endcase
                step_next  = step_reg + SB'(1);
                state_next = ST_ROW_READ;
            end
            ST_COPY_SRC:
            begin
                ram_raddr = src_byte[AB-1:LB];
                if (step_reg < cmd_reg.count)
                begin
                    state_next = ST_COPY_MID;
                end
                else
                begin
                    state_next = ST_DONE;
                end
            end
            ST_COPY_MID:
            begin
                bit_next   = ram_rdata[src_byte[LB-1:0]];
                ram_raddr  = dst_byte[AB-1:LB];
                state_next = ST_COPY_DST;
            end
            ST_COPY_DST:
            begin
                ram_we     = 1'b1;
                ram_waddr  = dst_byte[AB-1:LB];
                ram_wdata  = copy_word;
                step_next  = step_reg + SB'(1);
                state_next = ST_COPY_SRC;
            end
            ST_DONE:
            begin
                out_valid_next = 1'b1;
                out_mask_next  = ((cmd_reg.op == btp_pkg::OP_QUERY_MEM) ||
                                  (cmd_reg.op == btp_pkg::OP_QUERY_REG)) ? acc_reg : '0;
                state_next     = ST_IDLE;
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clr_reg       <= '0;
            init_reg      <= 1'b1;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_reg       <= clr_next;
            init_reg      <= init_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        cmd_reg      <= cmd_next;
        step_reg     <= step_next;
        acc_reg      <= acc_next;
        regbuf_reg   <= regbuf_next;
        bit_reg      <= bit_next;
        out_mask_reg <= out_mask_next;
    end

    // Register shadow with masked writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int e = 0; e < btp_pkg::REGISTER_COUNT; e++)
            begin
                rf_reg[e] <= '0;
            end
        end
        else
        begin
            for (int e = 0; e < btp_pkg::REGISTER_COUNT; e++)
            begin
                if (rf_clear)
                begin
                    rf_reg[e] <= '0;
                end
                else if (rf_we && (cmd_reg.ri == btp_pkg::RIDX_BITS'(e)))
                begin
                    rf_reg[e] <= (rf_reg[e] & ~rf_mask) | (rf_val & rf_mask);
                end
            end
        end
    end

endmodule

// ===== hdl/btp_checker.sv =====
// Port-level checks of the byte taint tracker and their binding.
`include "byte_taint_propagation_defines.svh"

module btp_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic [63:0] s_tdata,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [23:0] m_tdata
);

    logic [2:0] pending_reg, pending_next;
    logic       in_xfer;
    logic       out_xfer;

    assign in_xfer  = s_tvalid && s_tready;
    assign out_xfer = m_tvalid && m_tready;

    // Track transactions accepted but not yet answered
    always_comb
    begin
        pending_next = pending_reg + 3'(in_xfer) - 3'(out_xfer);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg <= 3'd0;
        end
        else
        begin
            pending_reg <= pending_next;
        end
    end

    `BTP_ASSERT_NOW(a_any_matches_mask, m_tvalid, m_tdata[16] == (m_tdata[15:0] != 16'd0), "any_tainted disagrees with mask")
    `BTP_ASSERT_NEXT(a_result_held, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "stalled result changed")
    `BTP_ASSERT_NOW(a_no_spurious_result, out_xfer, pending_reg != 3'd0, "result without a pending transaction")
    `BTP_ASSERT_NOW(a_pending_bound, 1'b1, pending_reg <= 3'd4, "more transactions in flight than storage")
    `BTP_ASSERT_NEXT(a_input_held, s_tvalid && !s_tready, s_tvalid && $stable(s_tdata), "waiting input transaction changed")

endmodule

bind byte_taint_propagation btp_checker u_btp_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

// ===== tb/sv/testbench.sv =====
// Self-checking testbench of the byte taint tracker: directed table, then random operations.
module testbench;

    // One row of the directed table; expected result is used only when known is set
    typedef struct {
        logic [3:0]  op;
        logic [15:0] addr;
        logic [15:0] saddr;
        logic [8:0]  span;
        logic [3:0]  ri;
        logic [2:0]  rp;
        logic [3:0]  si;
        logic [2:0]  sp;
        bit          known;
        logic [15:0] mask;
        logic        any;
    } op_row_t;

    typedef struct {
        logic [15:0] mask;
        logic        any;
    } taint_result_t;

    localparam int DIRECTED_ROWS = 24;
    localparam int RANDOM_ITEMS  = 1430;
    localparam int STALL_LIMIT   = 25000;
    localparam logic [3:0] OP_UNUSED_LO = 4'd11;
    localparam logic [3:0] OP_UNUSED_HI = 4'd15;
    localparam logic [2:0] PART_BAD_LO  = 3'd6;
    localparam logic [2:0] PART_BAD_HI  = 3'd7;

    op_row_t plan [DIRECTED_ROWS] = '{
        '{btp_pkg::OP_QUERY_MEM,   16'h0000, 16'h0000, 9'd16,  4'd0,  btp_pkg::PART_LOW,
          4'd0, btp_pkg::PART_LOW,  1'b1, 16'h0000, 1'b0},
        '{btp_pkg::OP_QUERY_REG,   16'h0000, 16'h0000, 9'd0,   4'd15, btp_pkg::PART_OWORD,
          4'd0, btp_pkg::PART_LOW,  1'b1, 16'h0000, 1'b0},
        '{btp_pkg::OP_TAINT_MEM,   16'hFFF8, 16'h0000, 9'd16,  4'd0,  btp_pkg::PART_LOW,
          4'd0, btp_pkg::PART_LOW,  1'b1, 16'h0000, 1'b0},
        '{btp_pkg::OP_QUERY_MEM,   16'hFFF8, 16'h0000, 9'd16,  4'd0,  btp_pkg::PART_LOW,
          4'd0, btp_pkg::PART_LOW,  1'b1, 16'hFFFF, 1'b1},
        '{btp_pkg::OP_QUERY_MEM,   16'hFFF8, 16'h0000, 9'd0,   4'd0,  btp_pkg::PART_LOW,
          4'd0, btp_pkg::PART_LOW,  1'b1, 16'h0000, 1'b0},
        '{btp_pkg::OP_TAINT_REG,   16'h0000, 16'h0000, 9'd0,   4'd3,  btp_pkg::PART_OWORD,
          4'd0, btp_pkg::PART_LOW,  1'b1, 16'h0000, 1'b0},
        '{btp_pkg::OP_QUERY_REG,   16'h0000, 16'h0000, 9'd0,   4'd3,  btp_pkg::PART_OWORD,
          4'd0, btp_pkg::PART_LOW,  1'b1, 16'hFFFF, 1'b1},
        '{btp_pkg::OP_UNTAINT_REG, 16'h0000, 16'h0000, 9'd0,   4'd3,  PART_BAD_LO,
          4'd0, btp_pkg::PART_LOW,  1'b1, 16'h0000, 1'b0},
        '{btp_pkg::OP_QUERY_REG,   16'h0000, 16'h0000, 9'd0,   4'd3,  PART_BAD_HI,
          4'd0, btp_pkg::PART_LOW,  1'b1, 16'h0000, 1'b0},
        '{btp_pkg::OP_UNTAINT_REG, 16'h0000, 16'h0000, 9'd0,   4'd3,  btp_pkg::PART_HIGH,
          4'd0, btp_pkg::PART_LOW,  1'b0, 16'h0000, 1'b0},
        '{btp_pkg::OP_REG_TO_MEM,  16'h1000, 16'h0000, 9'd0,   4'd3,  btp_pkg::PART_HIGH,
          4'd0, btp_pkg::PART_LOW,  1'b0, 16'h0000, 1'b0},
        '{btp_pkg::OP_REG_TO_MEM,  16'h1008, 16'h0000, 9'd0,   4'd3,  btp_pkg::PART_QWORD,
          4'd0, btp_pkg::PART_LOW,  1'b0, 16'h0000, 1'b0},
        '{btp_pkg::OP_QUERY_MEM,   16'h1000, 16'h0000, 9'd16,  4'd0,  btp_pkg::PART_LOW,
          4'd0, btp_pkg::PART_LOW,  1'b0, 16'h0000, 1'b0},
        '{btp_pkg::OP_MEM_TO_REG,  16'h1008, 16'h0000, 9'd0,   4'd5,  btp_pkg::PART_HIGH,
          4'd0, btp_pkg::PART_LOW,  1'b0, 16'h0000, 1'b0},
        '{btp_pkg::OP_MEM_TO_REG,  16'hFFFC, 16'h0000, 9'd0,   4'd6,  btp_pkg::PART_QWORD,
          4'd0, btp_pkg::PART_LOW,  1'b0, 16'h0000, 1'b0},
        '{btp_pkg::OP_REG_TO_REG,  16'h0000, 16'h0000, 9'd0,   4'd7,  btp_pkg::PART_LOW,
          4'd5, btp_pkg::PART_HIGH, 1'b0, 16'h0000, 1'b0},
        '{btp_pkg::OP_REG_TO_REG,  16'h0000, 16'h0000, 9'd0,   4'd8,  btp_pkg::PART_DWORD,
          4'd3, btp_pkg::PART_LOW,  1'b0, 16'h0000, 1'b0},
        '{btp_pkg::OP_REG_TO_REG,  16'h0000, 16'h0000, 9'd0,   4'd8,  btp_pkg::PART_OWORD,
          4'd3, PART_BAD_HI,        1'b0, 16'h0000, 1'b0},
        '{btp_pkg::OP_MEM_TO_MEM,  16'hFFFA, 16'hFFF8, 9'd20,  4'd0,  btp_pkg::PART_LOW,
          4'd0, btp_pkg::PART_LOW,  1'b0, 16'h0000, 1'b0},
        '{btp_pkg::OP_UNTAINT_MEM, 16'hFF80, 16'h0000, 9'd511, 4'd0,  btp_pkg::PART_LOW,
          4'd0, btp_pkg::PART_LOW,  1'b1, 16'h0000, 1'b0},
        '{btp_pkg::OP_QUERY_MEM,   16'hFFF0, 16'h0000, 9'd300, 4'd0,  btp_pkg::PART_LOW,
          4'd0, btp_pkg::PART_LOW,  1'b0, 16'h0000, 1'b0},
        '{OP_UNUSED_LO,            16'hFFFF, 16'hFFFF, 9'd511, 4'd15, PART_BAD_HI,
          4'd15, PART_BAD_HI,       1'b1, 16'h0000, 1'b0},
        '{btp_pkg::OP_CLEAR,       16'h0000, 16'h0000, 9'd0,   4'd0,  btp_pkg::PART_LOW,
          4'd0, btp_pkg::PART_LOW,  1'b1, 16'h0000, 1'b0},
        '{btp_pkg::OP_QUERY_REG,   16'h0000, 16'h0000, 9'd0,   4'd3,  btp_pkg::PART_OWORD,
          4'd0, btp_pkg::PART_LOW,  1'b1, 16'h0000, 1'b0}
    };

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [63:0] s_tdata = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [23:0] m_tdata;

    // Shadow copy of the tracker state
    bit          mem_taint [0:65535];
    logic [15:0] reg_taint [0:15];

    taint_result_t pending_results [$];
    int  failures = 0;
    int  rx_cycles = 0;
    int  quiet_cycles = 0;
    bit  stimulus_done = 1'b0;

    byte_taint_propagation dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    initial
    begin
        forever #4 clk = ~clk;
    end

    // Bytes selected by a register part
    function automatic logic [15:0] part_bytes_sel(logic [2:0] p);
        case (p)
            btp_pkg::PART_LOW:   return 16'h0001;
            btp_pkg::PART_HIGH:  return 16'h0002;
            btp_pkg::PART_WORD:  return 16'h0003;
            btp_pkg::PART_DWORD: return 16'h000F;
            btp_pkg::PART_QWORD: return 16'h00FF;
            btp_pkg::PART_OWORD: return 16'hFFFF;
            default:             return 16'h0000;
        endcase
    endfunction

    // Apply one operation to the shadow state and return its result
    function automatic taint_result_t apply_taint_op(op_row_t r);
        taint_result_t res;
        logic [15:0] m;
        logic [15:0] d;
        logic [15:0] s;
        int n;
        m = part_bytes_sel(r.rp);
        d = reg_taint[r.ri];
        s = reg_taint[r.si];
        res.mask = '0;
        n = (r.span > 256) ? 256 : int'(r.span);
        case (r.op)
            btp_pkg::OP_TAINT_MEM, btp_pkg::OP_UNTAINT_MEM:
                for (int i = 0; i < n; i++)
                    mem_taint[16'(r.addr + i)] = (r.op == btp_pkg::OP_TAINT_MEM);
            btp_pkg::OP_TAINT_REG:   reg_taint[r.ri] = d | m;
            btp_pkg::OP_UNTAINT_REG: reg_taint[r.ri] = d & ~m;
            btp_pkg::OP_REG_TO_MEM:
                if (r.rp <= btp_pkg::PART_HIGH)
                    mem_taint[r.addr] = d[r.rp];
                else
                    for (int i = 0; i < 16; i++)
                        if (m[i]) mem_taint[16'(r.addr + i)] = d[i];
            btp_pkg::OP_MEM_TO_REG:
            begin
                if (r.rp <= btp_pkg::PART_HIGH)
                    d = mem_taint[r.addr] ? (d | m) : (d & ~m);
                else
                    for (int i = 0; i < 16; i++)
                        if (m[i]) d[i] = mem_taint[16'(r.addr + i)];
                reg_taint[r.ri] = d;
            end
            btp_pkg::OP_REG_TO_REG:
                if (r.rp <= btp_pkg::PART_HIGH && r.sp <= btp_pkg::PART_HIGH)
                    reg_taint[r.ri] = s[r.sp] ? (d | m) : (d & ~m);
                else if (m != 0 && part_bytes_sel(r.sp) != 0)
                    reg_taint[r.ri] = (d & ~m) | (s & m);
            btp_pkg::OP_MEM_TO_MEM:
                for (int i = 0; i < n; i++)
                    mem_taint[16'(r.addr + i)] = mem_taint[16'(r.saddr + i)];
            btp_pkg::OP_QUERY_MEM:
                for (int i = 0; i < ((r.span > 16) ? 16 : int'(r.span)); i++)
                    res.mask[i] = mem_taint[16'(r.addr + i)];
            btp_pkg::OP_QUERY_REG:   res.mask = d & m;
            btp_pkg::OP_CLEAR:
            begin
                foreach (mem_taint[i]) mem_taint[i] = 1'b0;
                foreach (reg_taint[i]) reg_taint[i] = '0;
            end
            default: ;
        endcase
        res.any = (res.mask != 0);
        return res;
    endfunction

    // Build a random operation, mostly around two hot windows so that copies meet taint
    function automatic op_row_t random_op();
        op_row_t r;
        int pick;
        pick = $urandom_range(0, 999);
        if (pick < 4)
            r.op = btp_pkg::OP_CLEAR;
        else if (pick < 30)
            r.op = 4'($urandom_range(OP_UNUSED_LO, OP_UNUSED_HI));
        else
            r.op = 4'($urandom_range(btp_pkg::OP_TAINT_MEM, btp_pkg::OP_QUERY_REG));
        r.addr  = ($urandom_range(0, 9) < 6)
                ? (($urandom_range(0, 3) == 0 ? 16'hFFC0 : 16'h2000) + 16'($urandom_range(0, 127)))
                : 16'($urandom);
        r.saddr = ($urandom_range(0, 9) < 6)
                ? (($urandom_range(0, 3) == 0 ? 16'hFFC0 : 16'h2000) + 16'($urandom_range(0, 127)))
                : 16'($urandom);
        pick = $urandom_range(0, 99);
        r.span = (pick < 70) ? 9'($urandom_range(0, 24))
               : (pick < 95) ? 9'($urandom_range(25, 300)) : 9'($urandom_range(0, 511));
        r.ri = 4'($urandom_range(0, 15));
        r.si = 4'($urandom_range(0, 15));
        r.rp = ($urandom_range(0, 19) == 0) ? 3'($urandom_range(6, 7)) : 3'($urandom_range(0, 5));
        r.sp = ($urandom_range(0, 19) == 0) ? 3'($urandom_range(6, 7)) : 3'($urandom_range(0, 5));
        r.known = 1'b0;
        r.mask = '0;
        r.any = 1'b0;
        return r;
    endfunction

    // Offer one operation and hold it until the transaction completes
    task automatic send_op(op_row_t r, int idx);
        taint_result_t want;
        s_tvalid <= 1'b1;
        s_tdata  <= {5'b0, r.sp, r.si, r.rp, r.ri, r.span, r.saddr, r.addr, r.op};
        @(posedge clk);
        while (!s_tready) @(posedge clk);
        want = apply_taint_op(r);
        if (r.known)
        begin
            want.mask = r.mask;
            want.any  = r.any;
        end
        pending_results.insert(pending_results.size(), want);
        // idle now and then, outside a quiet stretch
        if ((idx < 700 || idx > 950) && $urandom_range(0, 99) < 20)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
    endtask

    // Stimulus
    initial
    begin
        foreach (mem_taint[i]) mem_taint[i] = 1'b0;
        foreach (reg_taint[i]) reg_taint[i] = '0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        for (int k = 0; k < DIRECTED_ROWS; k++)
            send_op(plan[k], k);
        for (int k = 0; k < RANDOM_ITEMS; k++)
            send_op(random_op(), DIRECTED_ROWS + k);
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge clk);
        repeat (50) @(posedge clk);
        stimulus_done = 1'b1;
        if (failures == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

    // Receiver: random back-pressure, one long hold-off and one quiet stretch
    always @(posedge clk)
    begin
        rx_cycles <= rx_cycles + 1;
        if (rx_cycles >= 15000 && rx_cycles < 15600)
            m_tready <= 1'b0;
        else if (rx_cycles >= 22000 && rx_cycles < 28000)
            m_tready <= 1'b1;
        else
            m_tready <= ($urandom_range(0, 99) >= 20);
    end

    // Compare each result transaction with the oldest expectation
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            if (pending_results.size() == 0)
            begin
                $error("result with no expectation: taint_mask %h", m_tdata[15:0]);
                failures++;
            end
            else
            begin
                if (m_tdata[15:0] !== pending_results[0].mask)
                begin
                    $error("taint_mask expected %h actual %h",
                           pending_results[0].mask, m_tdata[15:0]);
                    failures++;
                end
                if (m_tdata[16] !== pending_results[0].any)
                begin
                    $error("any_tainted expected %b actual %b",
                           pending_results[0].any, m_tdata[16]);
                    failures++;
                end
                void'(pending_results.pop_front());
            end
        end
    end

    // Watchdog on cycles without any transaction
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT && !stimulus_done)
        begin
            $display("TB_ERROR");
            $finish;
        end
    end

endmodule

// ===== files.f =====
+incdir+hdl
hdl/btp_pkg.sv
hdl/btp_ram.sv
hdl/btp_front.sv
hdl/btp_queue.sv
hdl/btp_back.sv
hdl/byte_taint_propagation.sv
hdl/btp_checker.sv
tb/sv/testbench.sv
